[hw/rtl/deq_pkg.sv]
package deq_pkg;

    // Field widths of one transaction on each channel
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Class of a decoded operation
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_PEEK,
        KIND_NOP
    } deq_kind_t;

    // Decoded command handed from the front part to the back part
    typedef struct packed {
        deq_kind_t                  kind;
        logic                       at_front;
        logic signed [VALUE_W-1:0]  value;
    } deq_cmd_t;

endpackage

[hw/rtl/deq_if.sv]
interface deq_req_if import deq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0]        status;
    logic                       is_empty;
    logic [OCC_W-1:0]           occupancy;

    modport source (output valid, output read_value, output status, output is_empty,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input status, input is_empty,
                    input occupancy, output ready);
endinterface

[hw/rtl/double_ended_queue_top.sv]
// Channel | Dir | Payload                                      | Handshake
// req     | in  | opcode[2:0], push_value[31:0] signed         | valid/ready
// rsp     | out | read_value[31:0] signed, status[1:0],        | valid/ready
//         |     | is_empty, occupancy[4:0]                     |
//
// Each request yields one response. Push, error and unused opcodes are
// answered from the execute state; pop and peek add a read state for the
// registered read port of the entry store. A two-entry command queue sits
// in front. Reset clears control and response registers, not stored data.
// A stalled rsp fills the command queue, after which req.ready drops.
module double_ended_queue_top import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    logic       cmd_valid;
    logic       cmd_ready;
    deq_cmd_t   cmd;

    // Accept and classify transactions
    deq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // Carry out queue operations
    deq_back #(
        .DEPTH (DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule

[hw/rtl/deq_front.sv]
module deq_front import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    output logic        cmd_valid,
    output deq_cmd_t    cmd,
    input  logic        cmd_ready
);

    localparam int QDEPTH = 2;

    deq_cmd_t   q_reg [QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] q_count_reg;
    deq_cmd_t   dec;
    logic       q_push;
    logic       q_pop;

    // Classify the incoming opcode
    always_comb
    begin
        dec.value    = req.push_value;
        dec.at_front = 1'b0;
        dec.kind     = KIND_NOP;
        case (req.opcode)
            OP_PUSH_FRONT:
            begin
                dec.kind     = KIND_PUSH;
                dec.at_front = 1'b1;
            end
            OP_PUSH_BACK:
            begin
                dec.kind = KIND_PUSH;
            end
            OP_POP_FRONT:
            begin
                dec.kind     = KIND_POP;
                dec.at_front = 1'b1;
            end
            OP_POP_BACK:
            begin
                dec.kind = KIND_POP;
            end
            OP_PEEK_FRONT:
            begin
                dec.kind     = KIND_PEEK;
                dec.at_front = 1'b1;
            end
            OP_PEEK_BACK:
            begin
                dec.kind = KIND_PEEK;
            end
            default:
            begin
                dec.kind = KIND_NOP;
            end
        endcase
    end

    // Command queue handshakes
    assign req.ready = (q_count_reg != 2'(QDEPTH));
    assign q_push    = req.valid && req.ready;
    assign cmd_valid = (q_count_reg != 2'd0);
    assign q_pop     = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            q_count_reg <= 2'd0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (q_push && !q_pop)
            begin
                q_count_reg <= q_count_reg + 2'd1;
            end
            else if (q_pop && !q_push)
            begin
                q_count_reg <= q_count_reg - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/deq_back.sv]
module deq_back import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  deq_cmd_t    cmd,
    output logic        cmd_ready,
    deq_rsp_if.source   rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);

    typedef enum logic {
        S_EXEC,
        S_READ
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           front_reg, front_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic signed [VALUE_W-1:0]  rsp_value_reg, rsp_value_next;
    logic [STATUS_W-1:0]        rsp_status_reg, rsp_status_next;
    logic                       rsp_empty_reg, rsp_empty_next;
    logic [OCC_W-1:0]           rsp_occ_reg, rsp_occ_next;

    logic signed [VALUE_W-1:0]  mem [DEPTH];
    logic signed [VALUE_W-1:0]  rd_data_reg;
    logic                       mem_we;
    logic                       mem_re;
    logic [IDX_W-1:0]           mem_wr_addr;
    logic [IDX_W-1:0]           mem_rd_addr;

    logic                       take;
    logic                       is_full;
    logic                       is_empty;
    logic [IDX_W-1:0]           front_dec;
    logic [IDX_W-1:0]           front_inc;
    logic [IDX_W:0]             push_sum;
    logic [IDX_W:0]             back_sum;
    logic [IDX_W-1:0]           push_slot;
    logic [IDX_W-1:0]           back_slot;

    // Slot arithmetic modulo DEPTH
    assign is_full   = (count_reg == DEPTH_CNT);
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign push_sum  = (IDX_W + 1)'(front_reg) + (IDX_W + 1)'(IDX_W'(count_reg));
    assign back_sum  = (IDX_W + 1)'(front_reg) + (IDX_W + 1)'(IDX_W'(count_reg - 1'b1));
    assign push_slot = (push_sum >= DEPTH_SUM) ? IDX_W'(push_sum - DEPTH_SUM)
                                               : IDX_W'(push_sum);
    assign back_slot = (back_sum >= DEPTH_SUM) ? IDX_W'(back_sum - DEPTH_SUM)
                                               : IDX_W'(back_sum);

    // Take a command only in the execute state, when the response register is free or frees up this cycle
    assign cmd_ready = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);
    assign take      = cmd_valid && cmd_ready;

    // Execute one command
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_occ_next    = rsp_occ_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wr_addr     = front_reg;
        mem_rd_addr     = front_reg;
        case (state_reg)
            S_EXEC:
            begin
                if (take)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = '0;
                    rsp_status_next = ST_OK;
                    case (cmd.kind)
                        KIND_PUSH:
                        begin
                            if (is_full)
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.at_front)
                                begin
                                    mem_wr_addr = front_dec;
                                    front_next  = front_dec;
                                end
                                else
                                begin
                                    mem_wr_addr = push_slot;
                                end
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (is_empty)
                            begin
                                rsp_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                mem_rd_addr    = cmd.at_front ? front_reg : back_slot;
                                rsp_valid_next = 1'b0;
                                state_next     = S_READ;
                                if (cmd.kind == KIND_POP)
                                begin
                                    count_next = count_reg - 1'b1;
                                    if (cmd.at_front)
                                    begin
                                        front_next = front_inc;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_occ_next   = OCC_W'(count_next);
                    rsp_empty_next = (count_next == '0);
                end
            end
            S_READ:
            begin
                rsp_valid_next  = 1'b1;
                rsp_value_next  = rd_data_reg;
                rsp_status_next = ST_OK;
                rsp_occ_next    = OCC_W'(count_reg);
                rsp_empty_next  = is_empty;
                state_next      = S_EXEC;
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    // Hold state, pointers and the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_EXEC;
            front_reg      <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_value_reg  <= '0;
            rsp_status_reg <= ST_OK;
            rsp_empty_reg  <= 1'b1;
            rsp_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
            rsp_empty_reg  <= rsp_empty_next;
            rsp_occ_reg    <= rsp_occ_next;
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= cmd.value;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.is_empty   = rsp_empty_reg;
    assign rsp.occupancy  = rsp_occ_reg;

    // Count never exceeds the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above depth");

    // The read cycle always finds the response register free
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !rsp_valid_reg)
        else $error("response register busy during read");

    // A held response reports the current occupancy
    a_rsp_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_occ_reg == OCC_W'(count_reg))
        else $error("response occupancy out of step with count");

    // A store write grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance count");

    // A full status only comes from a full store
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg == ST_FULL |-> count_reg == DEPTH_CNT)
        else $error("full status with room left");

endmodule

[verif/double_ended_queue_top_test.sv]
`timescale 1ns / 100ps

module double_ended_queue_top_test;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int RAND_ITEMS  = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    // Opcodes the block ignores
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    // Idle styles for each side
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 1;
    localparam int IDLE_LIGHT = 2;

    // Generator phases
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;

    typedef struct {
        logic [OPCODE_W-1:0]        opcode;
        logic signed [VALUE_W-1:0]  value;
    } deq_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0]        status;
        logic                       is_empty;
        logic [OCC_W-1:0]           occupancy;
    } deq_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Local copies of the driven inputs, known from time zero
    logic                       drv_valid  = 1'b0;
    logic [OPCODE_W-1:0]        drv_opcode = '0;
    logic signed [VALUE_W-1:0]  drv_value  = '0;
    logic                       drv_ready  = 1'b0;

    deq_req_if req ();
    deq_rsp_if rsp ();

    assign req.valid      = drv_valid;
    assign req.opcode     = drv_opcode;
    assign req.push_value = drv_value;
    assign rsp.ready      = drv_ready;

    double_ended_queue_top #(.DEPTH(DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Free-running clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    deq_item_t   req_backlog[$];
    deq_result_t awaited_rsp[$];
    bit          failed = 1'b0;
    int          cycle_count = 0;

    // Mirror of the deque contents
    logic signed [VALUE_W-1:0]  mirror_store [DEPTH];
    logic [SLOT_W-1:0]          head_slot = '0;
    logic [OCC_W-1:0]           held = '0;

    // Apply one operation to the mirror and return the response it yields
    function automatic deq_result_t apply_deque_op(input logic [OPCODE_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] word);
        deq_result_t       r;
        logic [SLOT_W-1:0] slot;
        r.read_value = '0;
        r.status     = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held == DEPTH)
                    r.status = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                begin
                    head_slot = head_slot - 1'b1;
                    mirror_store[head_slot] = word;
                    held = held + 1'b1;
                end
                else
                begin
                    slot = head_slot + held[SLOT_W-1:0];
                    mirror_store[slot] = word;
                    held = held + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                        slot = head_slot;
                    else
                        slot = head_slot + held[SLOT_W-1:0] - 1'b1;
                    r.read_value = mirror_store[slot];
                    if (op == OP_POP_FRONT)
                    begin
                        head_slot = head_slot + 1'b1;
                        held = held - 1'b1;
                    end
                    else if (op == OP_POP_BACK)
                        held = held - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.is_empty  = (held == 0);
        r.occupancy = held;
        return r;
    endfunction

    // Pick the wait before the next transaction; switch idle style per stretch
    function automatic int draw_idle(inout int mode, inout int stretch);
        if (stretch == 0)
        begin
            mode    = $urandom_range(IDLE_LIGHT, IDLE_NONE);
            stretch = $urandom_range(20, 120);
        end
        stretch--;
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_HEAVY: return $urandom_range(0, 17);
            default:    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 0;
        endcase
    endfunction

    // Word for a push: extremes now and then, random bits otherwise
    function automatic logic signed [VALUE_W-1:0] draw_word();
        case ($urandom_range(0, 15))
            0:       return {1'b0, {(VALUE_W-1){1'b1}}};
            1:       return {1'b1, {(VALUE_W-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_item(input logic [OPCODE_W-1:0] op,
                                       input logic signed [VALUE_W-1:0] word);
        deq_item_t it;
        it.opcode = op;
        it.value  = word;
        req_backlog.push_back(it);
    endfunction

    // Compare one response against the oldest expectation
    task automatic check_response();
        deq_result_t want;
        if (awaited_rsp.size() == 0)
        begin
            $error("response with none expected: read_value %0d status %0d",
                   rsp.read_value, rsp.status);
            failed = 1'b1;
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (rsp.read_value !== want.read_value)
            begin
                $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
                failed = 1'b1;
            end
            if (rsp.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, rsp.status);
                failed = 1'b1;
            end
            if (rsp.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
                failed = 1'b1;
            end
            if (rsp.occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, rsp.occupancy);
                failed = 1'b1;
            end
        end
    endtask

    // Request driver: present queued items, predict each accepted transaction
    int send_hold    = 0;
    int send_mode    = IDLE_NONE;
    int send_stretch = 0;

    always @(posedge clk or negedge rst_n)
    begin
        deq_item_t nxt;
        logic      offering;
        if (!rst_n)
        begin
            drv_valid  <= 1'b0;
            drv_opcode <= '0;
            drv_value  <= '0;
            send_hold  = 0;
        end
        else
        begin
            offering = drv_valid;
            if (drv_valid && req.ready)
            begin
                awaited_rsp.push_back(apply_deque_op(drv_opcode, drv_value));
                offering  = 1'b0;
                send_hold = draw_idle(send_mode, send_stretch);
            end
            if (!offering)
            begin
                if (send_hold > 0)
                    send_hold--;
                else if (req_backlog.size() > 0)
                begin
                    nxt = req_backlog.pop_front();
                    drv_opcode <= nxt.opcode;
                    drv_value  <= nxt.value;
                    offering   = 1'b1;
                end
            end
            drv_valid <= offering;
        end
    end

    // Response monitor: check each accepted transaction, stall ready at random
    int recv_hold    = 0;
    int recv_mode    = IDLE_NONE;
    int recv_stretch = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic rdy;
        if (!rst_n)
        begin
            drv_ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            rdy = drv_ready;
            if (rsp.valid && drv_ready)
            begin
                check_response();
                recv_hold = draw_idle(recv_mode, recv_stretch);
                rdy = (recv_hold == 0);
            end
            else if (!drv_ready)
            begin
                if (recv_hold > 0)
                    recv_hold--;
                rdy = (recv_hold == 0);
            end
            drv_ready <= rdy;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[double_ended_queue_top] ERROR");
            $finish;
        end
    end

    // Build the stimulus, run reset, wait for the last response
    initial
    begin
        int   counted;
        int   est;
        int   phase;
        int   pick;
        logic [OPCODE_W-1:0] op;

        // Empty-queue errors and ignored opcodes
        queue_item(OP_POP_FRONT, '0);
        queue_item(OP_POP_BACK, '1);
        queue_item(OP_PEEK_FRONT, '0);
        queue_item(OP_PEEK_BACK, '0);
        queue_item(OP_SPARE_6, 32'sd5);
        queue_item(OP_SPARE_7, '1);

        // Fill to the bound from both ends, mostly with extreme words
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i % 4)
                0: queue_item(OP_PUSH_FRONT, {1'b0, {(VALUE_W-1){1'b1}}});
                1: queue_item(OP_PUSH_BACK, {1'b1, {(VALUE_W-1){1'b0}}});
                2: queue_item(OP_PUSH_FRONT, '1);
                default: queue_item(OP_PUSH_BACK, (i == 3) ? '0 : $urandom);
            endcase
        end

        // Full-queue refusals, then peeks and pops at both ends
        queue_item(OP_PUSH_FRONT, 32'sd1);
        queue_item(OP_PUSH_BACK, 32'sd2);
        queue_item(OP_PEEK_FRONT, '0);
        queue_item(OP_PEEK_BACK, '0);
        queue_item(OP_POP_FRONT, '0);
        queue_item(OP_POP_BACK, '0);

        // Random walk between empty and full, with a little noise
        est     = DEPTH - 2;
        phase   = PHASE_DRAIN;
        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            if ((est == DEPTH || est == 0) && $urandom_range(0, 3) == 0)
                phase = (est == 0) ? PHASE_FILL : PHASE_DRAIN;
            else if ($urandom_range(0, 59) == 0)
                phase = (phase == PHASE_FILL) ? PHASE_DRAIN : PHASE_FILL;

            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            else if ((phase == PHASE_FILL) == (pick < 75))
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:    op = OP_POP_FRONT;
                    2, 3:    op = OP_POP_BACK;
                    4:       op = OP_PEEK_FRONT;
                    default: op = OP_PEEK_BACK;
                endcase
            end

            // Track the fill level the generator steers by
            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
            begin
                if (est < DEPTH)
                    est++;
            end
            else if (op == OP_POP_FRONT || op == OP_POP_BACK)
            begin
                if (est > 0)
                    est--;
            end

            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
                queue_item(op, draw_word());
            else
                queue_item(op, $urandom);
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                counted++;
        end

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain everything, sampling between edges once driver updates settle
        while (req_backlog.size() > 0 || drv_valid || awaited_rsp.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!failed)
            $display("[double_ended_queue_top] OK");
        else
            $display("[double_ended_queue_top] ERROR");
        $finish;
    end

endmodule
